[sv/mlet_pkg.sv]
// Package with shared types, constants and saturation helpers of the line envelope tree.
package mlet_pkg;

	localparam int NODE_COUNT_DEF = 4096;

	localparam logic signed [31:0] SLOPE_LIM = 32'sh4000_0000;
	localparam logic signed [62:0] ICPT_LIM  = 63'sh2000_0000_0000_0000;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	localparam logic CFG_LEFT  = 1'b0;
	localparam logic CFG_RIGHT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_READ,
		ST_INS_M1,
		ST_INS_M2,
		ST_INS_C1,
		ST_INS_C2,
		ST_ALLOC,
		ST_STORE_NEW,
		ST_Q_W1,
		ST_Q_W2
	} state_t;

	typedef struct packed {
		logic line_we;
		logic link_we;
	} store_we_t;

	function automatic logic signed [31:0] sat_coord(input logic signed [31:0] v);
		logic signed [31:0] r;
		if (v > SLOPE_LIM) begin
			r = SLOPE_LIM;
		end else if (v < -SLOPE_LIM) begin
			r = -SLOPE_LIM;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic signed [62:0] sat_icpt(input logic signed [62:0] v);
		logic signed [62:0] r;
		if (v > ICPT_LIM) begin
			r = ICPT_LIM;
		end else if (v < -ICPT_LIM) begin
			r = -ICPT_LIM;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[sv/mlet_mac.sv]
// Shared two-stage multiply-add unit that evaluates a line at one x coordinate.
module mlet_mac (
	input  logic               clk,
	input  logic signed [31:0] mul_a,
	input  logic signed [31:0] mul_b,
	input  logic signed [62:0] addend,
	output logic signed [62:0] sum
);

	logic signed [63:0] prod_s1;
	logic signed [62:0] addend_s1;
	logic signed [62:0] sum_s2;

	always_ff @(posedge clk) begin
		prod_s1   <= mul_a * mul_b;
		addend_s1 <= addend;
		sum_s2    <= prod_s1[62:0] + addend_s1;
	end

	assign sum = sum_s2;

endmodule

[sv/mlet_store.sv]
// Node pool memories holding each node's line and its child links.
module mlet_store #(
	parameter int NODE_COUNT = mlet_pkg::NODE_COUNT_DEF
) (
	input  logic                            clk,
	input  logic [$clog2(NODE_COUNT)-1:0]   rd_addr,
	input  logic [$clog2(NODE_COUNT)-1:0]   wr_addr,
	input  mlet_pkg::store_we_t             we,
	input  logic signed [31:0]              wr_slope,
	input  logic signed [62:0]              wr_icpt,
	input  logic [$clog2(NODE_COUNT)-1:0]   wr_left,
	input  logic [$clog2(NODE_COUNT)-1:0]   wr_right,
	output logic signed [31:0]              rd_slope,
	output logic signed [62:0]              rd_icpt,
	output logic [$clog2(NODE_COUNT)-1:0]   rd_left,
	output logic [$clog2(NODE_COUNT)-1:0]   rd_right
);

	localparam int IW = $clog2(NODE_COUNT);

	logic signed [31:0] slope_mem [NODE_COUNT];
	logic signed [62:0] icpt_mem  [NODE_COUNT];
	logic [2*IW-1:0]    link_mem  [NODE_COUNT];
	logic [2*IW-1:0]    link_rd_q;

	always_ff @(posedge clk) begin
		if (we.line_we) begin
			slope_mem[wr_addr] <= wr_slope;
			icpt_mem[wr_addr]  <= wr_icpt;
		end
		if (we.link_we) begin
			link_mem[wr_addr] <= {wr_left, wr_right};
		end
		rd_slope  <= slope_mem[rd_addr];
		rd_icpt   <= icpt_mem[rd_addr];
		link_rd_q <= link_mem[rd_addr];
	end

	assign rd_left  = link_rd_q[2*IW-1:IW];
	assign rd_right = link_rd_q[IW-1:0];

endmodule

[sv/max_line_envelope_tree.sv]
// Top level of the line envelope tree: sequencer, node pool and shared multiply-add unit.
//
// The block keeps the upper envelope of inserted lines in a tree of up to NODE_COUNT nodes and
// works on one command at a time: start is taken while busy is low, and the result appears for
// exactly one cycle with done high, so the receiver must take it in that cycle. An insert runs
// ST_START, ST_READ and ST_INS states per level whose line it is compared against, ends in
// ST_READ if it fills the empty root, and adds ST_ALLOC and ST_STORE_NEW when it creates a
// node; a query runs ST_START and ST_READ per level plus ST_Q_W1 and ST_Q_W2 where the node
// holds a line. An empty domain ends either command in ST_START; done is registered from the
// last state. Node memory reads are registered, and for an insert the two-stage multiply-add
// unit evaluates the new line and the node's line in turn. Domain registers are written
// through the cfg port while the block is idle. No memory clearing is needed after reset.
module max_line_envelope_tree #(
	parameter int NODE_COUNT = mlet_pkg::NODE_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic signed [31:0] line_slope,
	input  logic signed [62:0] line_intercept,
	input  logic signed [30:0] query_x,
	output logic               done,
	output logic signed [62:0] max_value,
	output logic               line_found,
	output logic               status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int IW = $clog2(NODE_COUNT);
	localparam int UW = $clog2(NODE_COUNT + 1);

	mlet_pkg::state_t state_q, state_d;

	logic signed [31:0] dom_left_q, dom_right_q;
	logic signed [31:0] l_q, r_q, mid_q, m_q, x_q, nslope_q;
	logic signed [62:0] b_q, nicpt_q, va_q, best_q;
	logic [IW-1:0]      ix_q, nleft_q, nright_q;
	logic [UW-1:0]      used_q;
	logic               act_q, found_q, dir_q;
	logic               root_has_q;
	logic [IW-1:0]      root_left_q, root_right_q;
	logic               done_q, res_found_q, res_status_q;
	logic signed [62:0] res_value_q;

	logic signed [31:0] rd_slope;
	logic signed [62:0] rd_icpt;
	logic [IW-1:0]      rd_left, rd_right;
	mlet_pkg::store_we_t mem_we;
	logic [IW-1:0]      wr_addr, wr_left, wr_right;
	logic signed [31:0] wr_slope;
	logic signed [62:0] wr_icpt;

	logic signed [31:0] mac_a, mac_b;
	logic signed [62:0] mac_c, mac_sum;

	logic signed [32:0] mid_sum;
	logic signed [31:0] mid_calc;
	logic               has_node;
	logic [IW-1:0]      cur_left, cur_right, nav_child;
	logic               nav_right, nav_left;
	logic               swap, go_right, go_left;
	logic signed [31:0] kslope, dslope, new_l, new_r;
	logic signed [62:0] dicpt;
	logic [IW-1:0]      ins_child;
	logic signed [62:0] best_nxt;
	logic               found_nxt;
	logic               fin, fin_status;
	logic [IW-1:0]      used_idx;

	assign busy      = (state_q != mlet_pkg::ST_IDLE);
	assign cfg_ready = ~busy;
	assign done       = done_q;
	assign max_value  = res_value_q;
	assign line_found = res_found_q;
	assign status     = res_status_q;

	assign mid_sum  = {l_q[31], l_q} + {r_q[31], r_q};
	assign mid_calc = mid_sum[32:1];
	assign has_node = (ix_q != '0) || root_has_q;
	assign used_idx = used_q[IW-1:0];

	assign cur_left  = (state_q == mlet_pkg::ST_READ) ?
		((ix_q == '0) ? root_left_q : rd_left) : nleft_q;
	assign cur_right = (state_q == mlet_pkg::ST_READ) ?
		((ix_q == '0) ? root_right_q : rd_right) : nright_q;
	assign nav_right = (x_q > mid_q);
	assign nav_left  = (x_q < mid_q);
	assign nav_child = nav_right ? cur_right : cur_left;

	assign swap      = (va_q > mac_sum);
	assign kslope    = swap ? m_q : nslope_q;
	assign dslope    = swap ? nslope_q : m_q;
	assign dicpt     = swap ? nicpt_q : b_q;
	assign go_right  = (dslope > kslope);
	assign go_left   = (dslope < kslope);
	assign new_l     = go_right ? (mid_q + 32'sd1) : l_q;
	assign new_r     = go_left ? mid_q : r_q;
	assign ins_child = go_right ? nright_q : nleft_q;

	assign found_nxt = found_q | (state_q == mlet_pkg::ST_Q_W2);
	assign best_nxt  = ((state_q == mlet_pkg::ST_Q_W2) && (!found_q || (mac_sum > best_q))) ?
		mac_sum : best_q;

	mlet_mac u_mac (
		.clk    (clk),
		.mul_a  (mac_a),
		.mul_b  (mac_b),
		.addend (mac_c),
		.sum    (mac_sum)
	);

	mlet_store #(
		.NODE_COUNT (NODE_COUNT)
	) u_store (
		.clk      (clk),
		.rd_addr  (ix_q),
		.wr_addr  (wr_addr),
		.we       (mem_we),
		.wr_slope (wr_slope),
		.wr_icpt  (wr_icpt),
		.wr_left  (wr_left),
		.wr_right (wr_right),
		.rd_slope (rd_slope),
		.rd_icpt  (rd_icpt),
		.rd_left  (rd_left),
		.rd_right (rd_right)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlet_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mem_we     = '0;
		wr_addr    = ix_q;
		wr_slope   = m_q;
		wr_icpt    = b_q;
		wr_left    = '0;
		wr_right   = '0;
		mac_a      = m_q;
		mac_b      = mid_q;
		mac_c      = b_q;
		fin        = 1'b0;
		fin_status = 1'b0;
		unique case (state_q)
			mlet_pkg::ST_IDLE: begin
				if (start) begin
					state_d = mlet_pkg::ST_START;
				end
			end
			mlet_pkg::ST_START: begin
				if (r_q <= l_q) begin
					fin = 1'b1;
				end else begin
					state_d = mlet_pkg::ST_READ;
				end
			end
			mlet_pkg::ST_READ: begin
				if (act_q == mlet_pkg::ACT_INSERT) begin
					if (!has_node) begin
						mem_we.line_we = 1'b1;
						fin = 1'b1;
					end else begin
						state_d = mlet_pkg::ST_INS_M1;
					end
				end else if (has_node) begin
					mac_a   = rd_slope;
					mac_b   = x_q;
					mac_c   = rd_icpt;
					state_d = mlet_pkg::ST_Q_W1;
				end else if (!(nav_right || nav_left) || (nav_child == '0)) begin
					fin = 1'b1;
				end else begin
					state_d = mlet_pkg::ST_START;
				end
			end
			mlet_pkg::ST_INS_M1: begin
				state_d = mlet_pkg::ST_INS_M2;
			end
			mlet_pkg::ST_INS_M2: begin
				mac_a   = nslope_q;
				mac_c   = nicpt_q;
				state_d = mlet_pkg::ST_INS_C1;
			end
			mlet_pkg::ST_INS_C1: begin
				state_d = mlet_pkg::ST_INS_C2;
			end
			mlet_pkg::ST_INS_C2: begin
				mem_we.line_we = swap;
				if (!(go_right || go_left) || (new_r <= new_l)) begin
					fin = 1'b1;
				end else if (ins_child != '0) begin
					state_d = mlet_pkg::ST_START;
				end else if (used_q >= UW'(NODE_COUNT)) begin
					fin        = 1'b1;
					fin_status = 1'b1;
				end else begin
					state_d = mlet_pkg::ST_ALLOC;
				end
			end
			mlet_pkg::ST_ALLOC: begin
				mem_we.link_we = (ix_q != '0);
				wr_left        = dir_q ? nleft_q : used_idx;
				wr_right       = dir_q ? used_idx : nright_q;
				state_d        = mlet_pkg::ST_STORE_NEW;
			end
			mlet_pkg::ST_STORE_NEW: begin
				mem_we.line_we = 1'b1;
				mem_we.link_we = 1'b1;
				wr_addr        = used_idx;
				fin            = 1'b1;
			end
			mlet_pkg::ST_Q_W1: begin
				state_d = mlet_pkg::ST_Q_W2;
			end
			mlet_pkg::ST_Q_W2: begin
				if (!(nav_right || nav_left) || (nav_child == '0)) begin
					fin = 1'b1;
				end else begin
					state_d = mlet_pkg::ST_START;
				end
			end
			default: begin
				state_d = mlet_pkg::ST_IDLE;
			end
		endcase
		if (fin) begin
			state_d = mlet_pkg::ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dom_left_q   <= '0;
			dom_right_q  <= mlet_pkg::SLOPE_LIM;
			root_has_q   <= 1'b0;
			root_left_q  <= '0;
			root_right_q <= '0;
			used_q       <= UW'(1);
			done_q       <= 1'b0;
		end else begin
			done_q <= fin;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					mlet_pkg::CFG_LEFT:  dom_left_q  <= mlet_pkg::sat_coord(cfg_data);
					mlet_pkg::CFG_RIGHT: dom_right_q <= mlet_pkg::sat_coord(cfg_data);
					default: ;
				endcase
			end
			if ((state_q == mlet_pkg::ST_READ) && (act_q == mlet_pkg::ACT_INSERT) && !has_node) begin
				root_has_q <= 1'b1;
			end
			if ((state_q == mlet_pkg::ST_ALLOC) && (ix_q == '0)) begin
				if (dir_q) begin
					root_right_q <= used_idx;
				end else begin
					root_left_q <= used_idx;
				end
			end
			if (state_q == mlet_pkg::ST_STORE_NEW) begin
				used_q <= used_q + UW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mlet_pkg::ST_IDLE: begin
				l_q     <= dom_left_q;
				r_q     <= dom_right_q;
				ix_q    <= '0;
				act_q   <= action;
				m_q     <= mlet_pkg::sat_coord(line_slope);
				b_q     <= mlet_pkg::sat_icpt(line_intercept);
				x_q     <= {query_x[30], query_x};
				found_q <= 1'b0;
				best_q  <= '0;
			end
			mlet_pkg::ST_START: begin
				mid_q <= mid_calc;
			end
			mlet_pkg::ST_READ: begin
				nslope_q <= rd_slope;
				nicpt_q  <= rd_icpt;
				nleft_q  <= cur_left;
				nright_q <= cur_right;
				if ((act_q == mlet_pkg::ACT_QUERY) && !has_node) begin
					if (nav_right) begin
						l_q <= mid_q + 32'sd1;
					end else begin
						r_q <= mid_q;
					end
					ix_q <= nav_child;
				end
			end
			mlet_pkg::ST_INS_C1: begin
				va_q <= mac_sum;
			end
			mlet_pkg::ST_INS_C2: begin
				m_q   <= dslope;
				b_q   <= dicpt;
				l_q   <= new_l;
				r_q   <= new_r;
				dir_q <= go_right;
				if (ins_child != '0) begin
					ix_q <= ins_child;
				end
			end
			mlet_pkg::ST_Q_W2: begin
				best_q  <= best_nxt;
				found_q <= found_nxt;
				if (nav_right) begin
					l_q <= mid_q + 32'sd1;
				end else begin
					r_q <= mid_q;
				end
				ix_q <= nav_child;
			end
			default: ;
		endcase
		if (fin) begin
			res_value_q  <= ((act_q == mlet_pkg::ACT_QUERY) && found_nxt) ? best_nxt : '0;
			res_found_q  <= (act_q == mlet_pkg::ACT_QUERY) && found_nxt;
			res_status_q <= (act_q == mlet_pkg::ACT_INSERT) && fin_status;
		end
	end

endmodule
